### src/wvp_pkg.sv
// shared constants and types for the video window partitioner
// no dependencies; imported by every module of the block
package wvp_pkg;

  // fixed register and field widths
  localparam int AREA_W     = 16;
  localparam int WIN_W      = 4;
  localparam int CAP_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_AXES   = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOWS_T   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOWS_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOWS_W   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_CAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_TARGET = 3'd4;

  // register reset values
  localparam logic [WIN_W-1:0]  RST_WINDOWS_T   = 4'd4;
  localparam logic [WIN_W-1:0]  RST_WINDOWS_H   = 4'd3;
  localparam logic [WIN_W-1:0]  RST_WINDOWS_W   = 4'd3;
  localparam logic [CAP_W-1:0]  RST_FRAME_CAP   = 10'd30;
  localparam logic [AREA_W-1:0] RST_AREA_TARGET = 16'd3600;

  // axis slots inside a job
  localparam logic [1:0] AX_T = 2'd0;
  localparam logic [1:0] AX_H = 2'd1;
  localparam logic [1:0] AX_W = 2'd2;

  // setup operation sequence of the front end
  localparam logic [2:0] OP_RATIO_H = 3'd0;
  localparam logic [2:0] OP_RATIO_W = 3'd1;
  localparam logic [2:0] OP_SIZE_H  = 3'd2;
  localparam logic [2:0] OP_SIZE_W  = 3'd3;
  localparam logic [2:0] OP_SIZE_T  = 3'd4;
  localparam logic [2:0] OP_CNT_T   = 3'd5;
  localparam logic [2:0] OP_CNT_H   = 3'd6;
  localparam logic [2:0] OP_CNT_W   = 3'd7;

  // job queue depth
  localparam int QUEUE_DEPTH = 2;

  // front end sequencer
  typedef enum logic [7:0] {
    F_IDLE = 8'b0000_0001,
    F_GO   = 8'b0000_0010,
    F_DIV  = 8'b0000_0100,
    F_SQRT = 8'b0000_1000,
    F_CNT  = 8'b0001_0000,
    F_TOT1 = 8'b0010_0000,
    F_TOT2 = 8'b0100_0000,
    F_PUSH = 8'b1000_0000
  } front_state_t;

endpackage

### src/video_window_partitioner.sv
// setup: from request beat to job handoff the front end runs eight serial divisions, two
// square roots, then counting, totals and handoff; the divider sets the setup time
// throughput: one window per cycle while out_stall is low, up to MAX_RESULTS per job
// reset: synchronous active-high rst restores the register defaults and empties queue
// top level: front end, job queue and window emitter; depends on wvp_pkg
module video_window_partitioner import wvp_pkg::*; #(
  parameter int DIM_BITS    = 10,
  parameter int MAX_RESULTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DIM_BITS-1:0]   frames,
  input  logic [DIM_BITS-1:0]   height,
  input  logic [DIM_BITS-1:0]   width,
  input  logic                  shifted,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIM_BITS-1:0]   start_t,
  output logic [DIM_BITS-1:0]   end_t,
  output logic [DIM_BITS-1:0]   start_h,
  output logic [DIM_BITS-1:0]   end_h,
  output logic [DIM_BITS-1:0]   start_w,
  output logic [DIM_BITS-1:0]   end_w,
  output logic                  last,
  output logic                  overflow
);

  localparam int JOB_W = NUM_AXES * (3 * DIM_BITS + 2) + 1;

  logic             fj_valid, fj_stall, bj_valid, bj_stall;
  logic [JOB_W-1:0] fj_data, bj_data;

  // sizing front end
  wvp_front #(
    .DIM_BITS    (DIM_BITS),
    .MAX_RESULTS (MAX_RESULTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .frames    (frames),
    .height    (height),
    .width     (width),
    .shifted   (shifted),
    .job_valid (fj_valid),
    .job_stall (fj_stall),
    .job       (fj_data)
  );

  // job queue
  wvp_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fj_valid),
    .push_stall (fj_stall),
    .push_data  (fj_data),
    .pop_valid  (bj_valid),
    .pop_stall  (bj_stall),
    .pop_data   (bj_data)
  );

  // window emitter
  wvp_back #(
    .DIM_BITS    (DIM_BITS),
    .MAX_RESULTS (MAX_RESULTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (bj_valid),
    .job_stall (bj_stall),
    .job       (bj_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .start_t   (start_t),
    .end_t     (end_t),
    .start_h   (start_h),
    .end_h     (end_h),
    .start_w   (start_w),
    .end_w     (end_w),
    .last      (last),
    .overflow  (overflow)
  );

endmodule

### src/wvp_divider.sv
// serial restoring divider, one quotient bit per cycle
// depends on wvp_pkg; used by the front end for all setup divisions
module wvp_divider import wvp_pkg::*; #(
  parameter int NUMW = 28,
  parameter int DENW = 11
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NUMW-1:0] quo
);

  localparam int CNTW = $clog2(NUMW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DENW-1:0] rem;
  logic [DENW-1:0] den_r;
  logic [DENW:0]   rem_sh;
  logic            fits;

  // trial subtract
  assign rem_sh = {rem, quo[NUMW-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNTW'(NUMW);
        rem   <= '0;
        quo   <= num;
        den_r <= den;
      end else if (busy) begin
        rem <= fits ? DENW'(rem_sh - {1'b0, den_r}) : rem_sh[DENW-1:0];
        quo <= {quo[NUMW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/wvp_front.sv
// front end: config registers, request intake and window sizing
// depends on wvp_pkg and wvp_divider; hands one job per non-empty request to the queue
module wvp_front import wvp_pkg::*; #(
  parameter int DIM_BITS    = 10,
  parameter int MAX_RESULTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DIM_BITS-1:0]   frames,
  input  logic [DIM_BITS-1:0]   height,
  input  logic [DIM_BITS-1:0]   width,
  input  logic                  shifted,
  output logic                  job_valid,
  input  logic                  job_stall,
  output logic [NUM_AXES*(3*DIM_BITS+2):0] job
);

  localparam int D    = DIM_BITS;
  localparam int NUMW = AREA_W + D + 2;
  localparam int RW   = (NUMW + 1) / 2;
  localparam int RBW  = $clog2(RW);
  localparam int DENW = D + 1;
  localparam int MW   = (D > CAP_W) ? D : CAP_W;
  localparam int CW   = $clog2(MAX_RESULTS + 2);

  typedef struct packed {
    logic [D:0]   c;
    logic         k;
    logic [D-1:0] s;
    logic [D-1:0] d;
  } axis_job_t;

  typedef struct packed {
    logic                     ovf;
    axis_job_t [NUM_AXES-1:0] ax;
  } job_t;

  front_state_t state;
  logic [2:0]   op;

  logic [WIN_W-1:0]  win_t, win_h, win_w;
  logic [CAP_W-1:0]  cap;
  logic [AREA_W-1:0] area;

  logic [D-1:0]  dim  [NUM_AXES];
  logic [D-1:0]  size [NUM_AXES];
  logic [D:0]    cnt  [NUM_AXES];
  logic [RW-1:0] root [2];
  logic          shf;
  logic [NUMW-1:0] qr;
  logic [RW-1:0]   sq;
  logic [RBW-1:0]  sbit;
  logic [CW-1:0]   p1;
  logic            ovf;

  logic [WIN_W-1:0]  nt, nh, nw;
  logic [CAP_W-1:0]  cap_e;
  logic [AREA_W-1:0] area_e;
  logic              k [NUM_AXES];

  logic            div_start, div_done;
  logic [NUMW-1:0] div_num, div_quo;
  logic [DENW-1:0] div_den;

  // zero registers act as one
  assign nt     = (win_t == '0) ? WIN_W'(1) : win_t;
  assign nh     = (win_h == '0) ? WIN_W'(1) : win_h;
  assign nw     = (win_w == '0) ? WIN_W'(1) : win_w;
  assign cap_e  = (cap == '0) ? CAP_W'(1) : cap;
  assign area_e = (area == '0) ? AREA_W'(1) : area;

  // half-window shift only where the window is narrower than the axis
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      k[a] = shf && (size[a] < dim[a]);
    end
  end

  // ratio product area*extent, times four
  logic [D-1:0]        ratio_dim;
  logic [AREA_W+D-1:0] prod_a;
  logic [MW-1:0]       tmin;
  logic [1:0]          cax;

  assign ratio_dim = (op == OP_RATIO_H) ? dim[AX_H] : dim[AX_W];
  assign prod_a    = {{D{1'b0}}, area_e} * {{AREA_W{1'b0}}, ratio_dim};
  assign tmin      = (MW'(dim[AX_T]) < MW'(cap_e)) ? MW'(dim[AX_T]) : MW'(cap_e);

  // axis of a count operation
  always_comb begin
    unique case (op)
      OP_CNT_T: cax = AX_T;
      OP_CNT_H: cax = AX_H;
      default:  cax = AX_W;
    endcase
  end

  // divider operands per operation
  always_comb begin
    unique case (op)
      OP_RATIO_H: begin
        div_num = {prod_a, 2'b00};
        div_den = DENW'(dim[AX_W]);
      end
      OP_RATIO_W: begin
        div_num = {prod_a, 2'b00};
        div_den = DENW'(dim[AX_H]);
      end
      OP_SIZE_H: begin
        div_num = NUMW'(root[0]) + NUMW'(nh) - NUMW'(1);
        div_den = DENW'(nh);
      end
      OP_SIZE_W: begin
        div_num = NUMW'(root[1]) + NUMW'(nw) - NUMW'(1);
        div_den = DENW'(nw);
      end
      OP_SIZE_T: begin
        div_num = NUMW'(tmin) + NUMW'(nt) - NUMW'(1);
        div_den = DENW'(nt);
      end
      OP_CNT_T, OP_CNT_H, OP_CNT_W: begin
        div_num = NUMW'({dim[cax], 1'b0}) - NUMW'(k[cax])
                + NUMW'({size[cax], 1'b0}) - NUMW'(1);
        div_den = {size[cax], 1'b0};
      end
      default: begin
        div_num = '0;
        div_den = DENW'(1);
      end
    endcase
  end

  assign div_start = (state == F_GO);

  wvp_divider #(
    .NUMW (NUMW),
    .DENW (DENW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // size clamp to [1, extent]
  function automatic logic [D-1:0] fix_size(input logic [NUMW-1:0] q,
                                             input logic [D-1:0] d);
    logic [D-1:0] r;
    begin
      if (q == '0) r = D'(1);
      else if (q > NUMW'(d)) r = d;
      else r = q[D-1:0];
      return r;
    end
  endfunction

  // square root, one bit per cycle
  logic [RW-1:0]   cand, sq_next;
  logic [2*RW-1:0] cand_sq;
  logic [RW:0]     sq_inc;

  assign cand    = sq | (RW'(1) << sbit);
  assign cand_sq = {{RW{1'b0}}, cand} * {{RW{1'b0}}, cand};
  assign sq_next = (cand_sq <= (2*RW)'(qr)) ? cand : sq;
  assign sq_inc  = {1'b0, sq_next} + (RW+1)'(1);

  // non-empty window count of one axis
  logic [D:0]       n_ax;
  logic [D+1:0]     m_ax;
  logic [2*D+1:0]   lo2_last;
  logic             tail_empty, head_empty;
  logic [D:0]       c_val;

  assign n_ax       = qr[D:0] + (D+1)'(k[cax]);
  assign m_ax       = {n_ax, 1'b0} - (D+2)'(3);
  assign lo2_last   = {{D{1'b0}}, m_ax} * {{(D+2){1'b0}}, size[cax]};
  assign tail_empty = k[cax] && (lo2_last[2*D+1:1] >= (2*D+1)'(dim[cax]));
  assign head_empty = k[cax] && (size[cax] == D'(1));
  assign c_val      = n_ax - (D+1)'(head_empty) - (D+1)'(tail_empty);

  // overflow check, product saturated above the result limit
  logic [2*D+1:0]  p_th;
  logic [CW+D:0]   p_all;

  assign p_th  = {{(D+1){1'b0}}, cnt[AX_T]} * {{(D+1){1'b0}}, cnt[AX_H]};
  assign p_all = {{(D+1){1'b0}}, p1} * {{CW{1'b0}}, cnt[AX_W]};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      op    <= OP_RATIO_H;
      win_t <= RST_WINDOWS_T;
      win_h <= RST_WINDOWS_H;
      win_w <= RST_WINDOWS_W;
      cap   <= RST_FRAME_CAP;
      area  <= RST_AREA_TARGET;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_WINDOWS_T:   win_t <= cfg_data[WIN_W-1:0];
          REG_WINDOWS_H:   win_h <= cfg_data[WIN_W-1:0];
          REG_WINDOWS_W:   win_w <= cfg_data[WIN_W-1:0];
          REG_FRAME_CAP:   cap   <= cfg_data[CAP_W-1:0];
          REG_AREA_TARGET: area  <= cfg_data[AREA_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            dim[AX_T] <= frames;
            dim[AX_H] <= height;
            dim[AX_W] <= width;
            shf       <= shifted;
            op        <= OP_RATIO_H;
            // an empty volume gives no windows
            if (frames != '0 && height != '0 && width != '0) state <= F_GO;
          end
        end
        F_GO: state <= F_DIV;
        F_DIV: begin
          if (div_done) begin
            case (op)
              OP_RATIO_H, OP_RATIO_W: begin
                qr    <= div_quo;
                sq    <= '0;
                sbit  <= RBW'(RW - 1);
                state <= F_SQRT;
              end
              OP_SIZE_H: begin
                size[AX_H] <= fix_size(div_quo, dim[AX_H]);
                op         <= op + 3'd1;
                state      <= F_GO;
              end
              OP_SIZE_W: begin
                size[AX_W] <= fix_size(div_quo, dim[AX_W]);
                op         <= op + 3'd1;
                state      <= F_GO;
              end
              OP_SIZE_T: begin
                size[AX_T] <= fix_size(div_quo, dim[AX_T]);
                op         <= op + 3'd1;
                state      <= F_GO;
              end
              default: begin
                qr    <= div_quo;
                state <= F_CNT;
              end
            endcase
          end
        end
        F_SQRT: begin
          sq <= sq_next;
          if (sbit == '0) begin
            root[op[0]] <= sq_inc[RW:1];
            op          <= op + 3'd1;
            state       <= F_GO;
          end else begin
            sbit <= sbit - 1'b1;
          end
        end
        F_CNT: begin
          cnt[cax] <= c_val;
          if (op == OP_CNT_W) begin
            state <= F_TOT1;
          end else begin
            op    <= op + 3'd1;
            state <= F_GO;
          end
        end
        F_TOT1: begin
          p1    <= (p_th > (2*D+2)'(MAX_RESULTS)) ? CW'(MAX_RESULTS + 1) : CW'(p_th);
          state <= F_TOT2;
        end
        F_TOT2: begin
          ovf   <= p_all > (CW+D+1)'(MAX_RESULTS);
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!job_stall) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // job packing
  job_t job_w;
  always_comb begin
    job_w.ovf = ovf;
    for (int a = 0; a < NUM_AXES; a++) begin
      job_w.ax[a].c = cnt[a];
      job_w.ax[a].k = k[a];
      job_w.ax[a].s = size[a];
      job_w.ax[a].d = dim[a];
    end
  end

  assign job       = job_w;
  assign job_valid = (state == F_PUSH);
  assign in_stall  = (state != F_IDLE);

endmodule

### src/wvp_queue.sv
// two-entry job queue between front end and window emitter
// depends on wvp_pkg for its depth
module wvp_queue import wvp_pkg::*; #(
  parameter int WIDTH = 97
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_stall,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_stall,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CNW-1:0]   fill;
  logic             push, pop;

  assign push_stall = (fill == CNW'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slot[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  // pointer and fill tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= push_data;
        wr_ptr       <= wr_ptr + 1'b1;
      end
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + CNW'(push) - CNW'(pop);
    end
  end

endmodule

### src/wvp_back.sv
// back end: walks w, h, t window indexes and emits one window per beat
// depends on wvp_pkg; takes jobs from the queue, drives the output register
module wvp_back import wvp_pkg::*; #(
  parameter int DIM_BITS    = 10,
  parameter int MAX_RESULTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  output logic                  job_stall,
  input  logic [NUM_AXES*(3*DIM_BITS+2):0] job,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIM_BITS-1:0]   start_t,
  output logic [DIM_BITS-1:0]   end_t,
  output logic [DIM_BITS-1:0]   start_h,
  output logic [DIM_BITS-1:0]   end_h,
  output logic [DIM_BITS-1:0]   start_w,
  output logic [DIM_BITS-1:0]   end_w,
  output logic                  last,
  output logic                  overflow
);

  localparam int D  = DIM_BITS;
  localparam int AW = D + 3;
  localparam int NW = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [D:0]   c;
    logic         k;
    logic [D-1:0] s;
    logic [D-1:0] d;
  } axis_job_t;

  typedef struct packed {
    logic                     ovf;
    axis_job_t [NUM_AXES-1:0] ax;
  } job_t;

  job_t          cur, job_in;
  logic          busy;
  logic [NW-1:0] emitted;
  logic [D:0]    j   [NUM_AXES];
  logic [AW-1:0] h2  [NUM_AXES];
  logic          zf  [NUM_AXES];

  logic [D-1:0]  lo  [NUM_AXES];
  logic [D-1:0]  hi  [NUM_AXES];
  logic          ax_last [NUM_AXES];
  logic [AW-1:0] h2_init [NUM_AXES];
  logic          zf_init [NUM_AXES];
  logic [AW-1:0] s2  [NUM_AXES];
  logic          final_win, adv;

  assign job_in = job;

  // bounds of the current window; h2 holds twice the exclusive end
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      s2[a]      = AW'({cur.ax[a].s, 1'b0});
      lo[a]      = zf[a] ? '0 : D'((h2[a] - s2[a]) >> 1);
      hi[a]      = ((D+2)'(h2[a][AW-1:1]) > (D+2)'(cur.ax[a].d)) ?
                   cur.ax[a].d : D'(h2[a][AW-1:1]);
      ax_last[a] = (j[a] == cur.ax[a].c - (D+1)'(1));
    end
  end

  // start point of each axis for an incoming job, skipping an empty first window
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      zf_init[a] = !(job_in.ax[a].k && job_in.ax[a].s == D'(1));
      if (!job_in.ax[a].k)               h2_init[a] = AW'({job_in.ax[a].s, 1'b0});
      else if (job_in.ax[a].s == D'(1))  h2_init[a] = AW'(3);
      else                               h2_init[a] = AW'(job_in.ax[a].s);
    end
  end

  assign final_win = (ax_last[AX_T] && ax_last[AX_H] && ax_last[AX_W]) ||
                     ((emitted + NW'(1)) == NW'(MAX_RESULTS));
  assign adv       = busy && (!out_valid || !out_stall);
  assign job_stall = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      emitted   <= '0;
    end else begin
      // load a new job
      if (!busy && job_valid) begin
        busy    <= 1'b1;
        cur     <= job_in;
        emitted <= '0;
        for (int a = 0; a < NUM_AXES; a++) begin
          j[a]  <= '0;
          h2[a] <= h2_init[a];
          zf[a] <= zf_init[a];
        end
      end
      // emit one window
      if (adv) begin
        out_valid <= 1'b1;
        start_t   <= lo[AX_T];
        end_t     <= hi[AX_T];
        start_h   <= lo[AX_H];
        end_h     <= hi[AX_H];
        start_w   <= lo[AX_W];
        end_w     <= hi[AX_W];
        last      <= final_win;
        overflow  <= cur.ovf;
        emitted   <= emitted + NW'(1);
        if (final_win) busy <= 1'b0;
        // t is the inner loop, w the outer
        if (!ax_last[AX_T]) begin
          j[AX_T]  <= j[AX_T] + (D+1)'(1);
          h2[AX_T] <= h2[AX_T] + s2[AX_T];
          zf[AX_T] <= 1'b0;
        end else begin
          j[AX_T]  <= '0;
          h2[AX_T] <= cur.ax[AX_T].k ? ((cur.ax[AX_T].s == D'(1)) ? AW'(3) :
                      AW'(cur.ax[AX_T].s)) : s2[AX_T];
          zf[AX_T] <= !(cur.ax[AX_T].k && cur.ax[AX_T].s == D'(1));
          if (!ax_last[AX_H]) begin
            j[AX_H]  <= j[AX_H] + (D+1)'(1);
            h2[AX_H] <= h2[AX_H] + s2[AX_H];
            zf[AX_H] <= 1'b0;
          end else begin
            j[AX_H]  <= '0;
            h2[AX_H] <= cur.ax[AX_H].k ? ((cur.ax[AX_H].s == D'(1)) ? AW'(3) :
                        AW'(cur.ax[AX_H].s)) : s2[AX_H];
            zf[AX_H] <= !(cur.ax[AX_H].k && cur.ax[AX_H].s == D'(1));
            j[AX_W]  <= j[AX_W] + (D+1)'(1);
            h2[AX_W] <= h2[AX_W] + s2[AX_W];
            zf[AX_W] <= 1'b0;
          end
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### dv/tb.sv
// self-checking testbench for video_window_partitioner
// carries its own window predictor; depends on wvp_pkg and the block RTL
`timescale 1ns / 1ps

module tb;
  import wvp_pkg::*;

  localparam int DIM     = 10;
  localparam int MAXWIN  = 64;
  localparam int SETTLE  = 400;
  localparam int WDOG    = 5000;

  typedef struct packed {
    logic [DIM-1:0] frames, height, width;
    logic           shifted;
  } request_t;

  typedef struct packed {
    logic [DIM-1:0] st, et, sh, eh, sw, ew;
    logic           lst, ovf;
  } window_t;

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic [DIM-1:0] frames = '0, height = '0, width = '0;
  logic shifted = 0;
  logic out_valid, out_stall = 1;
  logic [DIM-1:0] start_t, end_t, start_h, end_h, start_w, end_w;
  logic last, overflow;

  video_window_partitioner #(.DIM_BITS(DIM), .MAX_RESULTS(MAXWIN)) uut (.*);

  // predictor copy of the registers
  logic [WIN_W-1:0]  wins_t = RST_WINDOWS_T, wins_h = RST_WINDOWS_H, wins_w = RST_WINDOWS_W;
  logic [CAP_W-1:0]  cap_reg = RST_FRAME_CAP;
  logic [AREA_W-1:0] area_reg = RST_AREA_TARGET;

  request_t pending[$];
  window_t  windows_due[$];
  int errors = 0;
  bit quiet = 0;
  int idle_cnt = 0;

  initial forever #5 clk = ~clk;

  // round(sqrt(num/den)) with halves rounded up
  function automatic int unsigned root_ratio(longint unsigned num, longint unsigned den);
    int unsigned n = 0, c;
    longint unsigned m;
    for (int b = 16; b >= 0; b--) begin
      c = n | (1 << b);
      m = 2 * longint'(c) - 1;
      if (m * m * den <= 4 * num) n = c;
    end
    return n;
  endfunction

  function automatic int unsigned clamp_size(int unsigned s, int unsigned d);
    if (s == 0) s = 1;
    if (s > d) s = d;
    return s;
  endfunction

  function automatic void span(int unsigned i, int unsigned s, int unsigned k,
                               int unsigned d, output int unsigned lo, output int unsigned hi);
    longint unsigned e;
    e = ((2 * longint'(i) + 2 - k) * s) / 2;
    lo = (i == 0) ? 0 : int'(((2 * longint'(i) - k) * s) / 2);
    hi = (e > d) ? d : int'(e);
  endfunction

  // window list of one request, in w / h / t loop order
  function automatic void predict_windows(request_t r);
    int unsigned t, h, w, nt, nh, nw, cap, area, st, sh, sw, kt, kh, kw;
    int unsigned ct, ch, cw, n, lo, hi, et0, et1, eh0, eh1, ew0, ew1;
    int unsigned cnt[3];
    longint unsigned total;
    window_t win;
    int first;
    t = r.frames; h = r.height; w = r.width;
    if (t == 0 || h == 0 || w == 0) return;
    nt = wins_t ? wins_t : 1; nh = wins_h ? wins_h : 1; nw = wins_w ? wins_w : 1;
    cap = cap_reg ? cap_reg : 1; area = area_reg ? area_reg : 1;
    sh = clamp_size((root_ratio(longint'(area) * h, w) + nh - 1) / nh, h);
    sw = clamp_size((root_ratio(longint'(area) * w, h) + nw - 1) / nw, w);
    st = clamp_size(((t < cap ? t : cap) + nt - 1) / nt, t);
    kt = (r.shifted && st < t); kh = (r.shifted && sh < h); kw = (r.shifted && sw < w);
    ct = (2 * t - kt + 2 * st - 1) / (2 * st) + kt;
    ch = (2 * h - kh + 2 * sh - 1) / (2 * sh) + kh;
    cw = (2 * w - kw + 2 * sw - 1) / (2 * sw) + kw;
    cnt = '{0, 0, 0};
    for (int i = 0; i < ct; i++) begin span(i, st, kt, t, lo, hi); if (hi > lo) cnt[0]++; end
    for (int i = 0; i < ch; i++) begin span(i, sh, kh, h, lo, hi); if (hi > lo) cnt[1]++; end
    for (int i = 0; i < cw; i++) begin span(i, sw, kw, w, lo, hi); if (hi > lo) cnt[2]++; end
    total = longint'(cnt[0]) * cnt[1] * cnt[2];
    n = 0;
    first = windows_due.size();
    for (int iw = 0; iw < cw && n < MAXWIN; iw++) begin
      span(iw, sw, kw, w, ew0, ew1);
      if (ew1 <= ew0) continue;
      for (int ih = 0; ih < ch && n < MAXWIN; ih++) begin
        span(ih, sh, kh, h, eh0, eh1);
        if (eh1 <= eh0) continue;
        for (int it = 0; it < ct && n < MAXWIN; it++) begin
          span(it, st, kt, t, et0, et1);
          if (et1 <= et0) continue;
          win = '{DIM'(et0), DIM'(et1), DIM'(eh0), DIM'(eh1), DIM'(ew0), DIM'(ew1),
                  1'b0, total > MAXWIN};
          windows_due = {windows_due, win};
          n++;
        end
      end
    end
    if (n > 0) windows_due[first + n - 1].lst = 1'b1;
  endfunction

  // request driver with random idle bursts
  int in_gap = 0;
  always @(posedge clk) begin
    logic nv;
    request_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && !in_stall) nv = 1'b0;
      if (!nv) begin
        if (in_gap > 0) in_gap--;
        else if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 10);
        else if (pending.size() > 0) begin
          r = pending.pop_front();
          frames <= r.frames; height <= r.height; width <= r.width; shifted <= r.shifted;
          nv = 1'b1;
        end
      end
      in_valid <= nv;
    end
  end

  // result stall bursts
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // predict on accepted request beats, check accepted window beats
  always @(posedge clk) begin
    window_t exp_w;
    if (!rst) begin
      if (in_valid && !in_stall) predict_windows('{frames, height, width, shifted});
      if (out_valid && !out_stall) begin
        if (windows_due.size() == 0) begin
          $error("unexpected window beat");
          errors++;
        end else begin
          exp_w = windows_due.pop_front();
          if (start_t !== exp_w.st) begin
            $error("start_t exp %0d got %0d", exp_w.st, start_t); errors++;
          end
          if (end_t !== exp_w.et) begin
            $error("end_t exp %0d got %0d", exp_w.et, end_t); errors++;
          end
          if (start_h !== exp_w.sh) begin
            $error("start_h exp %0d got %0d", exp_w.sh, start_h); errors++;
          end
          if (end_h !== exp_w.eh) begin
            $error("end_h exp %0d got %0d", exp_w.eh, end_h); errors++;
          end
          if (start_w !== exp_w.sw) begin
            $error("start_w exp %0d got %0d", exp_w.sw, start_w); errors++;
          end
          if (end_w !== exp_w.ew) begin
            $error("end_w exp %0d got %0d", exp_w.ew, end_w); errors++;
          end
          if (last !== exp_w.lst) begin
            $error("last exp %0d got %0d", exp_w.lst, last); errors++;
          end
          if (overflow !== exp_w.ovf) begin
            $error("overflow exp %0d got %0d", exp_w.ovf, overflow); errors++;
          end
        end
      end
    end
  end

  // watchdog on handshake silence
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WINDOWS_T:   wins_t = val[WIN_W-1:0];
      REG_WINDOWS_H:   wins_h = val[WIN_W-1:0];
      REG_WINDOWS_W:   wins_w = val[WIN_W-1:0];
      REG_FRAME_CAP:   cap_reg = val[CAP_W-1:0];
      REG_AREA_TARGET: area_reg = val[AREA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int wt, int wh, int ww, int cap, int area);
    write_reg(REG_WINDOWS_T, CFG_DATA_W'(wt)); write_reg(REG_WINDOWS_H, CFG_DATA_W'(wh));
    write_reg(REG_WINDOWS_W, CFG_DATA_W'(ww)); write_reg(REG_FRAME_CAP, CFG_DATA_W'(cap));
    write_reg(REG_AREA_TARGET, CFG_DATA_W'(area));
  endtask

  // append one request to the pending list
  task automatic add_req(request_t r);
    pending = {pending, r};
  endtask

  // wait for all requests and windows, then let a zero-window request drain
  task automatic drain();
    do @(negedge clk); while (pending.size() > 0 || in_valid || windows_due.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // random requests: mostly small volumes, some full range, rare zero extents
  task automatic add_random(int cnt);
    request_t r;
    for (int i = 0; i < cnt; i++) begin
      r.shifted = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          r.frames = DIM'($urandom_range(0, 1023));
          r.height = DIM'($urandom_range(0, 1023));
          r.width  = DIM'($urandom_range(0, 1023));
        end
        3: begin
          r.frames = DIM'($urandom_range(0, 3));
          r.height = DIM'($urandom_range(0, 3));
          r.width  = DIM'($urandom_range(0, 3));
        end
        default: begin
          r.frames = DIM'($urandom_range(1, 60));
          r.height = DIM'($urandom_range(1, 120));
          r.width  = DIM'($urandom_range(1, 120));
        end
      endcase
      add_req(r);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // directed requests on reset register values
    add_req('{10'd1, 10'd1, 10'd1, 1'b0});
    add_req('{10'd1023, 10'd1023, 10'd1023, 1'b1});
    add_req('{10'd0, 10'd5, 10'd5, 1'b0});
    add_req('{10'd5, 10'd0, 10'd5, 1'b1});
    add_req('{10'd5, 10'd5, 10'd0, 1'b0});
    add_req('{10'd1, 10'd1023, 10'd1, 1'b1});
    add_req('{10'd1023, 10'd1, 10'd1, 1'b0});
    add_req('{10'd2, 10'd2, 10'd2, 1'b1});
    add_req('{10'd30, 10'd45, 10'd80, 1'b1});
    add_req('{10'd30, 10'd45, 10'd80, 1'b0});
    add_req('{10'd100, 10'd60, 10'd60, 1'b0});
    add_req('{10'd682, 10'd341, 10'd1000, 1'b1});
    add_random(20);
    drain();
    // smallest register values: tiny windows and overflow
    set_regs(1, 1, 1, 1, 1);
    add_req('{10'd7, 10'd9, 10'd11, 1'b1});
    add_random(20);
    drain();
    // largest legal values
    set_regs(8, 8, 8, 1023, 65535);
    add_req('{10'd1023, 10'd1023, 10'd1023, 1'b1});
    add_random(20);
    drain();
    // zero registers and out-of-range window counts
    set_regs(0, 0, 0, 0, 0);
    add_req('{10'd9, 10'd9, 10'd9, 1'b1});
    drain();
    set_regs(15, 15, 15, 1023, 65535);
    add_random(20);
    drain();
    // random registers, last stretch without idling
    set_regs($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
             $urandom_range(1, 1023), $urandom_range(1, 65535));
    add_random(26);
    do @(negedge clk); while (pending.size() > 10);
    quiet = 1;
    add_random(10);
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
src/wvp_pkg.sv
src/wvp_divider.sv
src/wvp_front.sv
src/wvp_queue.sv
src/wvp_back.sv
src/video_window_partitioner.sv
dv/tb.sv
